// ===== hw/rtl/dbd_pkg.sv =====
// dbd_pkg: shared types, constants and helpers for the detection box decode filter.
// No dependencies; used by every other file in hw/rtl.
package dbd_pkg;

    // network input geometry the anchor layout is built for
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 640;

    // field widths
    localparam int IDX_W     = 14;
    localparam int DAT_W     = 16;
    localparam int FRAME_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int NSTG      = 6;

    // grid geometry per scale level (strides 8, 16, 32)
    localparam int GW0 = IMAGE_WIDTH / 8;
    localparam int GW1 = IMAGE_WIDTH / 16;
    localparam int GW2 = IMAGE_WIDTH / 32;
    localparam int GH0 = IMAGE_HEIGHT / 8;
    localparam int GH1 = IMAGE_HEIGHT / 16;
    localparam int GH2 = IMAGE_HEIGHT / 32;
    localparam int BASE1 = GW0 * GH0;
    localparam int BASE2 = BASE1 + GW1 * GH1;
    localparam int TOTAL = BASE2 + GW2 * GH2;

    localparam int C_W    = IDX_W;
    localparam int GRID_W = 8;
    localparam int SH_W   = 3;

    // reciprocal divide: q = (c * RCP) >> RCP_K is exact for c < 2^IDX_W
    localparam int RCP_K = 24;
    localparam int RCP_W = 24;
    localparam int RCP0  = ((1 << RCP_K) + GW0 - 1) / GW0;
    localparam int RCP1  = ((1 << RCP_K) + GW1 - 1) / GW1;
    localparam int RCP2  = ((1 << RCP_K) + GW2 - 1) / GW2;

    // exp approximation
    localparam int EXP_W = 28;
    localparam logic signed [13:0] LOG2E     = 14'sd5909;
    localparam logic [DAT_W-1:0]   POLY_A    = 16'd43047;
    localparam logic [DAT_W-1:0]   POLY_B    = 16'd22489;
    localparam logic [17:0]        EXP_ONE   = 18'd65536;
    localparam logic [EXP_W-1:0]   EXP_MAX   = '1;

    // position widths (units of 2^-16 px)
    localparam int POS_W = 29;
    localparam int SIZE_W = 33;
    localparam int CMP_W = 36;

    typedef logic [NSTG-1:0] t_stage_en;

    typedef enum logic [1:0] {
        LVL_S8   = 2'd0,
        LVL_S16  = 2'd1,
        LVL_S32  = 2'd2,
        LVL_NONE = 2'd3
    } t_level;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THR = 2'd0,
        CFG_FRAME_W   = 2'd1,
        CFG_FRAME_H   = 2'd2
    } t_cfg_reg;

    function automatic logic [RCP_W-1:0] f_rcp(input t_level lvl);
        unique case (lvl)
            LVL_S8:  return RCP_W'(RCP0);
            LVL_S16: return RCP_W'(RCP1);
            LVL_S32: return RCP_W'(RCP2);
            default: return '0;
        endcase
    endfunction

    function automatic logic [GRID_W:0] f_grid_w(input t_level lvl);
        unique case (lvl)
            LVL_S8:  return (GRID_W+1)'(GW0);
            LVL_S16: return (GRID_W+1)'(GW1);
            LVL_S32: return (GRID_W+1)'(GW2);
            default: return '0;
        endcase
    endfunction

    function automatic logic [SH_W-1:0] f_stride_sh(input t_level lvl);
        unique case (lvl)
            LVL_S8:  return 3'd3;
            LVL_S16: return 3'd4;
            LVL_S32: return 3'd5;
            default: return 3'd0;
        endcase
    endfunction

    // clip to [0, hi]; hi below zero clips everything to 0
    function automatic logic [POS_W-1:0] f_clamp(input logic signed [CMP_W-1:0] v,
                                                 input logic signed [CMP_W-1:0] hi);
        logic signed [CMP_W-1:0] t;
        t = (v > hi) ? hi : v;
        return (t < 0) ? '0 : POS_W'(t);
    endfunction

    // 2^-16 px to Q12.4, saturating
    function automatic logic [DAT_W-1:0] f_q124(input logic [POS_W-1:0] v);
        logic [POS_W-13:0] r;
        r = v[POS_W-1:12];
        return (r > (POS_W-12)'(16'hFFFF)) ? 16'hFFFF : DAT_W'(r);
    endfunction

endpackage

// ===== hw/rtl/dbd_if.sv =====
// Channel interfaces for the detection box decode filter: anchor in, box out, config.
// Depends on dbd_pkg for field widths.
interface dbd_anchor_if;
    logic                            valid;
    logic                            ready;
    logic [dbd_pkg::IDX_W-1:0]       anchor_index;
    logic signed [dbd_pkg::DAT_W-1:0] center_x_offset;
    logic signed [dbd_pkg::DAT_W-1:0] center_y_offset;
    logic signed [dbd_pkg::DAT_W-1:0] log_width;
    logic signed [dbd_pkg::DAT_W-1:0] log_height;
    logic [dbd_pkg::DAT_W-1:0]       objectness;
    logic [dbd_pkg::DAT_W-1:0]       class_probability;

    modport source (output valid, anchor_index, center_x_offset, center_y_offset,
                    log_width, log_height, objectness, class_probability, input ready);
    modport sink (input valid, anchor_index, center_x_offset, center_y_offset,
                  log_width, log_height, objectness, class_probability, output ready);
endinterface

interface dbd_box_if;
    logic                      valid;
    logic                      ready;
    logic [dbd_pkg::DAT_W-1:0] box_left;
    logic [dbd_pkg::DAT_W-1:0] box_top;
    logic [dbd_pkg::DAT_W-1:0] box_width;
    logic [dbd_pkg::DAT_W-1:0] box_height;
    logic [dbd_pkg::DAT_W-1:0] confidence;

    modport source (output valid, box_left, box_top, box_width, box_height, confidence,
                    input ready);
    modport sink (input valid, box_left, box_top, box_width, box_height, confidence,
                  output ready);
endinterface

interface dbd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dbd_pkg::CFG_IDX_W-1:0] index;
    logic [dbd_pkg::DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dbd_locate.sv =====
// dbd_locate: stages 1-3, anchor index to level and grid cell, score and drop test.
// Depends on dbd_pkg.
module dbd_locate (
    input  logic                           i_clk,
    input  dbd_pkg::t_stage_en             i_en,
    input  logic [dbd_pkg::IDX_W-1:0]      i_idx,
    input  logic signed [dbd_pkg::DAT_W-1:0] i_offx,
    input  logic signed [dbd_pkg::DAT_W-1:0] i_offy,
    input  logic [dbd_pkg::DAT_W-1:0]      i_obj,
    input  logic [dbd_pkg::DAT_W-1:0]      i_cls,
    input  logic [dbd_pkg::DAT_W-1:0]      i_thr,
    output dbd_pkg::t_level                o_lvl,
    output logic [dbd_pkg::GRID_W-1:0]     o_gx,
    output logic [dbd_pkg::GRID_W-1:0]     o_gy,
    output logic signed [dbd_pkg::DAT_W-1:0] o_offx,
    output logic signed [dbd_pkg::DAT_W-1:0] o_offy,
    output logic [dbd_pkg::DAT_W-1:0]      o_score,
    output logic                           o_keep
);
    localparam int PW = dbd_pkg::C_W + dbd_pkg::RCP_W;

    dbd_pkg::t_level                  n_lvl;
    logic [dbd_pkg::C_W-1:0]          n_c;
    logic [2*dbd_pkg::DAT_W-1:0]      n_prod;

    // stage 1
    dbd_pkg::t_level                  r1_lvl;
    logic [dbd_pkg::C_W-1:0]          r1_c;
    logic [dbd_pkg::DAT_W-1:0]        r1_score;
    logic                             r1_pass;
    logic signed [dbd_pkg::DAT_W-1:0] r1_offx, r1_offy;
    // stage 2
    dbd_pkg::t_level                  r2_lvl;
    logic [dbd_pkg::C_W-1:0]          r2_c;
    logic [PW-1:0]                    r2_q;
    logic [dbd_pkg::DAT_W-1:0]        r2_score;
    logic                             r2_keep;
    logic signed [dbd_pkg::DAT_W-1:0] r2_offx, r2_offy;

    logic [dbd_pkg::GRID_W-1:0]       n_q8;
    logic [dbd_pkg::GRID_W+dbd_pkg::GRID_W:0] n_qw;

    always_comb begin
        priority if (32'(i_idx) < dbd_pkg::BASE1) begin
            n_lvl = dbd_pkg::LVL_S8;
            n_c   = i_idx;
        end else if (32'(i_idx) < dbd_pkg::BASE2) begin
            n_lvl = dbd_pkg::LVL_S16;
            n_c   = dbd_pkg::C_W'(32'(i_idx) - dbd_pkg::BASE1);
        end else if (32'(i_idx) < dbd_pkg::TOTAL) begin
            n_lvl = dbd_pkg::LVL_S32;
            n_c   = dbd_pkg::C_W'(32'(i_idx) - dbd_pkg::BASE2);
        end else begin
            n_lvl = dbd_pkg::LVL_NONE;
            n_c   = i_idx;
        end
    end

    assign n_prod = i_obj * i_cls;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_lvl   <= n_lvl;
            r1_c     <= n_c;
            r1_score <= n_prod[2*dbd_pkg::DAT_W-1:dbd_pkg::DAT_W];
            r1_pass  <= (i_obj >= i_thr);
            r1_offx  <= i_offx;
            r1_offy  <= i_offy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_lvl   <= r1_lvl;
            r2_c     <= r1_c;
            r2_q     <= r1_c * dbd_pkg::f_rcp(r1_lvl);
            r2_score <= r1_score;
            r2_keep  <= r1_pass && (r1_score > i_thr) && (r1_lvl != dbd_pkg::LVL_NONE);
            r2_offx  <= r1_offx;
            r2_offy  <= r1_offy;
        end
    end

    // row and column; only the low bits matter since both stay below 256 for a kept anchor
    assign n_q8 = r2_q[dbd_pkg::RCP_K +: dbd_pkg::GRID_W];
    assign n_qw = n_q8 * dbd_pkg::f_grid_w(r2_lvl);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_lvl   <= r2_lvl;
            o_gy    <= n_q8;
            o_gx    <= dbd_pkg::GRID_W'(r2_c[dbd_pkg::GRID_W-1:0] - n_qw[dbd_pkg::GRID_W-1:0]);
            o_score <= r2_score;
            o_keep  <= r2_keep;
            o_offx  <= r2_offx;
            o_offy  <= r2_offy;
        end
    end

endmodule

// ===== hw/rtl/dbd_exp.sv =====
// dbd_exp: stages 1-4, fixed-point exp of a Q4.12 log size, Q12.16 result, saturating.
// Depends on dbd_pkg.
module dbd_exp (
    input  logic                             i_clk,
    input  dbd_pkg::t_stage_en               i_en,
    input  logic signed [dbd_pkg::DAT_W-1:0] i_x,
    output logic [dbd_pkg::EXP_W-1:0]        o_e
);
    logic signed [30:0] r_t;
    logic signed [6:0]  r_n2, r_n3;
    logic [31:0]        r_fa, r_ff, r_b;
    logic [15:0]        r_a;
    logic [15:0]        n_f;
    logic [17:0]        n_p;
    logic [38:0]        n_up;
    logic [6:0]         n_neg;
    logic [17:0]        n_dn;
    logic [dbd_pkg::EXP_W-1:0] n_e;

    // t = x * log2(e); integer part is the top bits (floor), fraction below
    always_ff @(posedge i_clk) begin
        if (i_en[0]) r_t <= i_x * dbd_pkg::LOG2E;
    end

    assign n_f = r_t[23:8];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_n2 <= r_t[30:24];
            r_fa <= n_f * dbd_pkg::POLY_A;
            r_ff <= n_f * n_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_n3 <= r_n2;
            r_a  <= r_fa[31:16];
            r_b  <= r_ff[31:16] * dbd_pkg::POLY_B;
        end
    end

    always_comb begin
        n_p   = dbd_pkg::EXP_ONE + 18'(r_a) + 18'(r_b[31:16]);
        n_up  = 39'(n_p) << r_n3[4:0];
        n_neg = 7'(-r_n3);
        n_dn  = n_p >> n_neg;
        if (!r_n3[6]) begin
            if (r_n3 > 7'sd20 || n_up > 39'(dbd_pkg::EXP_MAX)) n_e = dbd_pkg::EXP_MAX;
            else n_e = n_up[dbd_pkg::EXP_W-1:0];
        end else begin
            n_e = dbd_pkg::EXP_W'(n_dn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) o_e <= n_e;
    end

endmodule

// ===== hw/rtl/dbd_box.sv =====
// dbd_box: stages 4-6 for one axis, center, edge clipping and Q12.4 output register.
// Depends on dbd_pkg; takes level and cell from dbd_locate and size from dbd_exp.
module dbd_box (
    input  logic                             i_clk,
    input  dbd_pkg::t_stage_en               i_en,
    input  dbd_pkg::t_level                  i_lvl,
    input  logic [dbd_pkg::GRID_W-1:0]       i_cell,
    input  logic signed [dbd_pkg::DAT_W-1:0] i_off,
    input  logic [dbd_pkg::EXP_W-1:0]        i_e,
    input  logic [dbd_pkg::FRAME_W-1:0]      i_frame,
    output logic [dbd_pkg::DAT_W-1:0]        o_pos,
    output logic [dbd_pkg::DAT_W-1:0]        o_size
);
    localparam int CW = dbd_pkg::CMP_W;

    logic signed [17:0]          r_ctr;
    logic [dbd_pkg::SH_W-1:0]    r_sh;
    logic [dbd_pkg::POS_W-1:0]   r_x1;
    logic [dbd_pkg::SIZE_W-1:0]  r_w;

    logic signed [CW-1:0]        n_lim;
    logic signed [34:0]          n_cx;
    logic [dbd_pkg::SIZE_W-1:0]  n_w;
    logic signed [34:0]          n_v;
    logic signed [CW-1:0]        n_s;
    logic [dbd_pkg::POS_W-1:0]   n_x2;

    assign n_lim = ($signed({23'b0, i_frame}) - 36'sd1) <<< 16;

    // stage 4: center in Q8.8 cell units
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_ctr <= 18'(i_off) + $signed({2'b0, i_cell, 8'b0});
            r_sh  <= dbd_pkg::f_stride_sh(i_lvl);
        end
    end

    // stage 5: scale by stride, left edge
    always_comb begin
        n_cx = 35'(r_ctr) <<< ({1'b0, r_sh} + 4'd8);
        n_w  = dbd_pkg::SIZE_W'({5'b0, i_e} << r_sh);
        n_v  = n_cx - $signed({3'b0, n_w[dbd_pkg::SIZE_W-1:1]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_x1 <= dbd_pkg::f_clamp(CW'(n_v), n_lim);
            r_w  <= n_w;
        end
    end

    // stage 6: right edge from the clipped left edge; sum stays below 2^34
    assign n_s  = $signed(CW'(r_x1) + CW'(r_w));
    assign n_x2 = dbd_pkg::f_clamp(n_s, n_lim);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            o_pos  <= dbd_pkg::f_q124(r_x1);
            o_size <= dbd_pkg::f_q124(n_x2 - r_x1);
        end
    end

endmodule

// ===== hw/rtl/detection_box_decode_filter.sv =====
// detection_box_decode_filter: top level, config registers, pipeline valid/stall control.
// Depends on dbd_pkg, dbd_if, dbd_locate, dbd_exp and dbd_box.
//
// Decodes one anchor-free detector anchor per beat into a clipped box and score, or drops
// it. The anchor index picks the stride-8/16/32 level and the grid cell; the anchor is
// dropped if objectness is below score_threshold, the score (objectness * class
// probability, Q0.16) is not above it, or the index is past the last anchor. Kept anchors
// give left/top/width/height in Q12.4 pixels and the score. Throughput is one anchor per
// clock while the output is not stalled; each beat passes through the six-stage pipeline
// (the exp approximation takes three multiplier stages and clipping two, with the
// reciprocal divide of the index in the locate stages). Each stage holds independently,
// so bubbles collapse under output backpressure and a new anchor is taken while a finished
// box waits. Write config only while the block is drained.
module detection_box_decode_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dbd_anchor_if.sink   i_anchor,
    dbd_cfg_if.sink      i_cfg,
    dbd_box_if.source    o_box
);
    logic [dbd_pkg::DAT_W-1:0]   r_score_thr;
    logic [dbd_pkg::FRAME_W-1:0] r_frame_w;
    logic [dbd_pkg::FRAME_W-1:0] r_frame_h;

    logic [dbd_pkg::NSTG-1:0]    r_v;
    dbd_pkg::t_stage_en          en;

    dbd_pkg::t_level                  lvl3;
    logic [dbd_pkg::GRID_W-1:0]       gx3, gy3;
    logic signed [dbd_pkg::DAT_W-1:0] offx3, offy3;
    logic [dbd_pkg::DAT_W-1:0]        score3;
    logic                             keep3;
    logic [dbd_pkg::EXP_W-1:0]        ew4, eh4;

    logic [dbd_pkg::DAT_W-1:0]   r_score4, r_score5, r_conf;
    logic                        r_keep4, r_keep5;

    // config writes; index 3 is ignored
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr <= 16'd16384;
            r_frame_w   <= 13'd640;
            r_frame_h   <= 13'd640;
        end else if (i_cfg.valid) begin
            unique case (dbd_pkg::t_cfg_reg'(i_cfg.index))
                dbd_pkg::CFG_SCORE_THR: r_score_thr <= i_cfg.data;
                dbd_pkg::CFG_FRAME_W:   r_frame_w   <= i_cfg.data[dbd_pkg::FRAME_W-1:0];
                dbd_pkg::CFG_FRAME_H:   r_frame_h   <= i_cfg.data[dbd_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        en[dbd_pkg::NSTG-1] = !r_v[dbd_pkg::NSTG-1] || o_box.ready;
        for (int k = dbd_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_anchor.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_anchor.valid;
            for (int k = 1; k < dbd_pkg::NSTG - 1; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
            // dropped anchors vanish here instead of taking the output register
            if (en[dbd_pkg::NSTG-1]) r_v[dbd_pkg::NSTG-1] <= r_v[dbd_pkg::NSTG-2] && r_keep5;
        end
    end

    dbd_locate u_locate (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_idx   (i_anchor.anchor_index),
        .i_offx  (i_anchor.center_x_offset),
        .i_offy  (i_anchor.center_y_offset),
        .i_obj   (i_anchor.objectness),
        .i_cls   (i_anchor.class_probability),
        .i_thr   (r_score_thr),
        .o_lvl   (lvl3),
        .o_gx    (gx3),
        .o_gy    (gy3),
        .o_offx  (offx3),
        .o_offy  (offy3),
        .o_score (score3),
        .o_keep  (keep3)
    );

    dbd_exp u_exp_w (.i_clk(i_clk), .i_en(en), .i_x(i_anchor.log_width),  .o_e(ew4));
    dbd_exp u_exp_h (.i_clk(i_clk), .i_en(en), .i_x(i_anchor.log_height), .o_e(eh4));

    dbd_box u_box_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_lvl   (lvl3),
        .i_cell  (gx3),
        .i_off   (offx3),
        .i_e     (ew4),
        .i_frame (r_frame_w),
        .o_pos   (o_box.box_left),
        .o_size  (o_box.box_width)
    );

    dbd_box u_box_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_lvl   (lvl3),
        .i_cell  (gy3),
        .i_off   (offy3),
        .i_e     (eh4),
        .i_frame (r_frame_h),
        .o_pos   (o_box.box_top),
        .o_size  (o_box.box_height)
    );

    // score rides along with stages 4-6, the keep flag with stages 4 and 5
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_score4 <= score3;
            r_keep4  <= keep3;
        end
        if (en[4]) begin
            r_score5 <= r_score4;
            r_keep5  <= r_keep4;
        end
        if (en[5]) r_conf <= r_score5;
    end

    assign o_box.valid      = r_v[dbd_pkg::NSTG-1];
    assign o_box.confidence = r_conf;

    // a delivered box always passed the score test
    a_score_above_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.valid |-> (o_box.confidence > r_score_thr))
        else $error("box delivered with score not above threshold");

    // for a frame width from 1 to 4096, the right edge never passes the frame
    a_right_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_box.valid && r_frame_w != 13'd0 && r_frame_w <= 13'd4096) |->
        ((17'(o_box.box_left) + 17'(o_box.box_width)) <= {r_frame_w - 13'd1, 4'b0}))
        else $error("box right edge beyond frame");

    a_bottom_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_box.valid && r_frame_h != 13'd0 && r_frame_h <= 13'd4096) |->
        ((17'(o_box.box_top) + 17'(o_box.box_height)) <= {r_frame_h - 13'd1, 4'b0}))
        else $error("box bottom edge beyond frame");

    // an empty pipeline must take input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> i_anchor.ready)
        else $error("empty pipeline not ready");

endmodule
